FILE: design/ink_pixel_stats_assert.svh
// Assertion macros for the ink statistics block
`ifndef INK_PIXEL_STATS_ASSERT_SVH
`define INK_PIXEL_STATS_ASSERT_SVH

`ifndef SYNTHESIS
`define IPS_ASSERT_SAME(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
        else $error("ink_pixel_stats assertion failed");
`define IPS_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
        else $error("ink_pixel_stats assertion failed");
`else
`define IPS_ASSERT_SAME(lbl, clk_s, rstn_s, ante, cons)
`define IPS_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons)
`endif

`endif

FILE: design/ips_pkg.sv
package ips_pkg;

    localparam int unsigned SIDE_W    = 12;
    localparam int unsigned POS_S_W   = 13;
    localparam int unsigned COUNT_W   = 23;
    localparam int unsigned EDGE_W    = 12;
    localparam int unsigned CHAN_W    = 8;
    localparam int unsigned QUOT_W    = 13;
    localparam int unsigned REM_W     = 11;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [CHAN_W-1:0]  WHITE_LEVEL     = 8'd245;
    localparam logic [CHAN_W-1:0]  LIGHT_LEVEL     = 8'd160;
    localparam logic [COUNT_W-1:0] VISIBLE_FLOOR   = 23'd24;
    localparam logic [REM_W-1:0]   VISIBLE_DIV_M1  = 11'd1999;
    localparam logic [SIDE_W-1:0]  WIDTH_RESET     = 12'd400;
    localparam logic [SIDE_W-1:0]  HEIGHT_RESET    = 12'd300;
    localparam logic [COUNT_W-1:0] COUNT_MAX       = '1;
    localparam logic [EDGE_W-1:0]  EDGE_MAX        = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic left;
        logic top;
        logic right;
        logic bottom;
    } edge_hit_t;

endpackage

FILE: design/ink_pixel_stats.sv
// Latency: a frame's result is registered at the edge that accepts its last pixel and
// shows on the outputs in the next cycle.
// Throughput: one pixel per cycle; the last pixel of a frame waits only while a previous
// result is still stalled at the output register.
// Reset: asynchronous, active low; frame size returns to 400 x 300 and all tallies clear.
module ink_pixel_stats #(
    parameter int MAX_SIDE = 2400
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [ips_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ips_pkg::SIDE_W-1:0]        cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [ips_pkg::CHAN_W-1:0]        red,
    input  logic [ips_pkg::CHAN_W-1:0]        green,
    input  logic [ips_pkg::CHAN_W-1:0]        blue,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [ips_pkg::COUNT_W-1:0]       ink_count,
    output logic [ips_pkg::COUNT_W-1:0]       light_ink_count,
    output logic [ips_pkg::SIDE_W-1:0]        min_col,
    output logic [ips_pkg::SIDE_W-1:0]        min_row,
    output logic signed [ips_pkg::POS_S_W-1:0] max_col,
    output logic signed [ips_pkg::POS_S_W-1:0] max_row,
    output logic [ips_pkg::EDGE_W-1:0]        left_edge_ink,
    output logic [ips_pkg::EDGE_W-1:0]        top_edge_ink,
    output logic [ips_pkg::EDGE_W-1:0]        right_edge_ink,
    output logic [ips_pkg::EDGE_W-1:0]        bottom_edge_ink,
    output logic                              visible_ink
);

`include "ink_pixel_stats_assert.svh"

    localparam logic [ips_pkg::POS_S_W-1:0] MAX_SIDE_X = ips_pkg::POS_S_W'(MAX_SIDE);
    localparam logic [ips_pkg::SIDE_W-1:0]  W_RST_EFF  =
        ({1'b0, ips_pkg::WIDTH_RESET} > MAX_SIDE_X) ? MAX_SIDE_X[ips_pkg::SIDE_W-1:0]
                                                    : ips_pkg::WIDTH_RESET;
    localparam logic [ips_pkg::SIDE_W-1:0]  H_RST_EFF  =
        ({1'b0, ips_pkg::HEIGHT_RESET} > MAX_SIDE_X) ? MAX_SIDE_X[ips_pkg::SIDE_W-1:0]
                                                     : ips_pkg::HEIGHT_RESET;
    localparam logic signed [ips_pkg::POS_S_W-1:0] NO_POS = '1;

    function automatic logic [ips_pkg::SIDE_W-1:0] eff_side(
        input logic [ips_pkg::SIDE_W-1:0] v
    );
        logic [ips_pkg::SIDE_W-1:0] t;
        t = (v == '0) ? ips_pkg::SIDE_W'(1) : v;
        if ({1'b0, t} > MAX_SIDE_X)
        begin
            t = MAX_SIDE_X[ips_pkg::SIDE_W-1:0];
        end
        return t;
    endfunction

    logic [ips_pkg::SIDE_W-1:0]          frame_width_reg;
    logic [ips_pkg::SIDE_W-1:0]          frame_height_reg;
    logic [ips_pkg::SIDE_W-1:0]          col_pos_reg, col_pos_next;
    logic [ips_pkg::SIDE_W-1:0]          row_pos_reg, row_pos_next;
    logic [ips_pkg::COUNT_W-1:0]         pixel_total_reg, pixel_total_next;
    logic [ips_pkg::QUOT_W-1:0]          quot_reg, quot_next;
    logic [ips_pkg::REM_W-1:0]           rem_reg, rem_next;
    logic [ips_pkg::COUNT_W-1:0]         ink_tally_reg, ink_tally_next;
    logic [ips_pkg::COUNT_W-1:0]         light_tally_reg, light_tally_next;
    logic [ips_pkg::SIDE_W-1:0]          box_min_col_reg, box_min_col_next;
    logic [ips_pkg::SIDE_W-1:0]          box_min_row_reg, box_min_row_next;
    logic signed [ips_pkg::POS_S_W-1:0]  box_max_col_reg, box_max_col_next;
    logic signed [ips_pkg::POS_S_W-1:0]  box_max_row_reg, box_max_row_next;
    logic [ips_pkg::EDGE_W-1:0]          edge_left_reg, edge_left_next;
    logic [ips_pkg::EDGE_W-1:0]          edge_top_reg, edge_top_next;
    logic [ips_pkg::EDGE_W-1:0]          edge_right_reg, edge_right_next;
    logic [ips_pkg::EDGE_W-1:0]          edge_bottom_reg, edge_bottom_next;
    logic                                out_valid_reg;
    logic [ips_pkg::COUNT_W-1:0]         ink_count_reg, light_ink_count_reg;
    logic [ips_pkg::SIDE_W-1:0]          min_col_reg, min_row_reg;
    logic signed [ips_pkg::POS_S_W-1:0]  max_col_reg, max_row_reg;
    logic [ips_pkg::EDGE_W-1:0]          left_edge_ink_reg, top_edge_ink_reg;
    logic [ips_pkg::EDGE_W-1:0]          right_edge_ink_reg, bottom_edge_ink_reg;
    logic                                visible_ink_reg;

    logic [ips_pkg::SIDE_W-1:0] w_eff, h_eff;
    logic                       last_col, last_row, frame_end;
    logic                       in_acc, is_ink, is_light, any_ink, vis;
    ips_pkg::edge_hit_t         hit;

    assign w_eff     = eff_side(frame_width_reg);
    assign h_eff     = eff_side(frame_height_reg);
    assign last_col  = col_pos_reg >= (w_eff - ips_pkg::SIDE_W'(1));
    assign last_row  = row_pos_reg >= (h_eff - ips_pkg::SIDE_W'(1));
    assign frame_end = last_col && last_row;
    assign in_stall  = out_valid_reg && out_stall && frame_end;
    assign in_acc    = in_valid && !in_stall;

    assign is_ink   = !(red >= ips_pkg::WHITE_LEVEL && green >= ips_pkg::WHITE_LEVEL
                        && blue >= ips_pkg::WHITE_LEVEL);
    assign is_light = red >= ips_pkg::LIGHT_LEVEL && green >= ips_pkg::LIGHT_LEVEL
                      && blue >= ips_pkg::LIGHT_LEVEL;

    assign hit.left   = is_ink && (col_pos_reg == '0);
    assign hit.top    = is_ink && (row_pos_reg == '0);
    assign hit.right  = is_ink && last_col;
    assign hit.bottom = is_ink && last_row;

    always_comb
    begin
        pixel_total_next = pixel_total_reg;
        quot_next        = quot_reg;
        rem_next         = rem_reg;
        if (pixel_total_reg != ips_pkg::COUNT_MAX)
        begin
            pixel_total_next = pixel_total_reg + ips_pkg::COUNT_W'(1);
            if (rem_reg == ips_pkg::VISIBLE_DIV_M1)
            begin
                rem_next  = '0;
                quot_next = quot_reg + ips_pkg::QUOT_W'(1);
            end
            else
            begin
                rem_next = rem_reg + ips_pkg::REM_W'(1);
            end
        end

        ink_tally_next   = ink_tally_reg;
        light_tally_next = light_tally_reg;
        box_min_col_next = box_min_col_reg;
        box_min_row_next = box_min_row_reg;
        box_max_col_next = box_max_col_reg;
        box_max_row_next = box_max_row_reg;
        edge_left_next   = edge_left_reg;
        edge_top_next    = edge_top_reg;
        edge_right_next  = edge_right_reg;
        edge_bottom_next = edge_bottom_reg;

        if (is_ink)
        begin
            if (ink_tally_reg != ips_pkg::COUNT_MAX)
            begin
                ink_tally_next = ink_tally_reg + ips_pkg::COUNT_W'(1);
            end
            if (is_light && light_tally_reg != ips_pkg::COUNT_MAX)
            begin
                light_tally_next = light_tally_reg + ips_pkg::COUNT_W'(1);
            end
            if (col_pos_reg < box_min_col_reg)
            begin
                box_min_col_next = col_pos_reg;
            end
            if (row_pos_reg < box_min_row_reg)
            begin
                box_min_row_next = row_pos_reg;
            end
            if ($signed({1'b0, col_pos_reg}) > box_max_col_reg)
            begin
                box_max_col_next = $signed({1'b0, col_pos_reg});
            end
            if ($signed({1'b0, row_pos_reg}) > box_max_row_reg)
            begin
                box_max_row_next = $signed({1'b0, row_pos_reg});
            end
        end

        if (hit.left && edge_left_reg != ips_pkg::EDGE_MAX)
        begin
            edge_left_next = edge_left_reg + ips_pkg::EDGE_W'(1);
        end
        if (hit.top && edge_top_reg != ips_pkg::EDGE_MAX)
        begin
            edge_top_next = edge_top_reg + ips_pkg::EDGE_W'(1);
        end
        if (hit.right && edge_right_reg != ips_pkg::EDGE_MAX)
        begin
            edge_right_next = edge_right_reg + ips_pkg::EDGE_W'(1);
        end
        if (hit.bottom && edge_bottom_reg != ips_pkg::EDGE_MAX)
        begin
            edge_bottom_next = edge_bottom_reg + ips_pkg::EDGE_W'(1);
        end

        col_pos_next = last_col ? '0 : col_pos_reg + ips_pkg::SIDE_W'(1);
        row_pos_next = row_pos_reg;
        if (last_col)
        begin
            row_pos_next = last_row ? '0 : row_pos_reg + ips_pkg::SIDE_W'(1);
        end
    end

    assign any_ink = !box_max_col_next[ips_pkg::POS_S_W-1];
    assign vis     = (ink_tally_next >= ips_pkg::VISIBLE_FLOOR)
                     && (ink_tally_next >= ips_pkg::COUNT_W'(quot_next));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= ips_pkg::WIDTH_RESET;
            frame_height_reg <= ips_pkg::HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (ips_pkg::cfg_index_t'(cfg_index))
                ips_pkg::CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                ips_pkg::CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default:                   frame_width_reg  <= frame_width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_pos_reg     <= '0;
            row_pos_reg     <= '0;
            pixel_total_reg <= '0;
            quot_reg        <= '0;
            rem_reg         <= '0;
            ink_tally_reg   <= '0;
            light_tally_reg <= '0;
            box_min_col_reg <= W_RST_EFF;
            box_min_row_reg <= H_RST_EFF;
            box_max_col_reg <= NO_POS;
            box_max_row_reg <= NO_POS;
            edge_left_reg   <= '0;
            edge_top_reg    <= '0;
            edge_right_reg  <= '0;
            edge_bottom_reg <= '0;
        end
        else if (in_acc)
        begin
            col_pos_reg <= col_pos_next;
            row_pos_reg <= row_pos_next;
            if (frame_end)
            begin
                // clear the frame state for the next frame
                pixel_total_reg <= '0;
                quot_reg        <= '0;
                rem_reg         <= '0;
                ink_tally_reg   <= '0;
                light_tally_reg <= '0;
                box_min_col_reg <= w_eff;
                box_min_row_reg <= h_eff;
                box_max_col_reg <= NO_POS;
                box_max_row_reg <= NO_POS;
                edge_left_reg   <= '0;
                edge_top_reg    <= '0;
                edge_right_reg  <= '0;
                edge_bottom_reg <= '0;
            end
            else
            begin
                pixel_total_reg <= pixel_total_next;
                quot_reg        <= quot_next;
                rem_reg         <= rem_next;
                ink_tally_reg   <= ink_tally_next;
                light_tally_reg <= light_tally_next;
                box_min_col_reg <= box_min_col_next;
                box_min_row_reg <= box_min_row_next;
                box_max_col_reg <= box_max_col_next;
                box_max_row_reg <= box_max_row_next;
                edge_left_reg   <= edge_left_next;
                edge_top_reg    <= edge_top_next;
                edge_right_reg  <= edge_right_next;
                edge_bottom_reg <= edge_bottom_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_acc && frame_end)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // hold the result until its transaction completes
    always_ff @(posedge clk)
    begin
        if (in_acc && frame_end)
        begin
            ink_count_reg       <= ink_tally_next;
            light_ink_count_reg <= light_tally_next;
            min_col_reg         <= any_ink ? box_min_col_next : '0;
            min_row_reg         <= any_ink ? box_min_row_next : '0;
            max_col_reg         <= any_ink ? box_max_col_next : NO_POS;
            max_row_reg         <= any_ink ? box_max_row_next : NO_POS;
            left_edge_ink_reg   <= edge_left_next;
            top_edge_ink_reg    <= edge_top_next;
            right_edge_ink_reg  <= edge_right_next;
            bottom_edge_ink_reg <= edge_bottom_next;
            visible_ink_reg     <= vis;
        end
    end

    assign out_valid       = out_valid_reg;
    assign ink_count       = ink_count_reg;
    assign light_ink_count = light_ink_count_reg;
    assign min_col         = min_col_reg;
    assign min_row         = min_row_reg;
    assign max_col         = max_col_reg;
    assign max_row         = max_row_reg;
    assign left_edge_ink   = left_edge_ink_reg;
    assign top_edge_ink    = top_edge_ink_reg;
    assign right_edge_ink  = right_edge_ink_reg;
    assign bottom_edge_ink = bottom_edge_ink_reg;
    assign visible_ink     = visible_ink_reg;

    `IPS_ASSERT_NEXT(a_clear_after_frame, clk, rst_n, in_acc && frame_end,
        col_pos_reg == '0 && row_pos_reg == '0 && ink_tally_reg == '0 && out_valid_reg)
    `IPS_ASSERT_SAME(a_hold_last_pixel, clk, rst_n, out_valid_reg && out_stall && frame_end,
        in_stall)
    `IPS_ASSERT_SAME(a_empty_box, clk, rst_n, out_valid_reg && max_col == NO_POS,
        ink_count == '0 && min_col == '0 && min_row == '0 && max_row == NO_POS)
    `IPS_ASSERT_SAME(a_light_within_ink, clk, rst_n, out_valid_reg,
        light_ink_count <= ink_count)

endmodule
